@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file rcst_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/rcst_pkg.sv @@
// Shared constants and types for the range cap / range max segment tree.
package rcst_pkg;

    localparam int LEAVES  = 1024;
    localparam int IDX_W   = 11;
    localparam int NODE_AW = $clog2(2 * LEAVES);
    localparam int VAL_W   = 31;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CAP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef struct packed {
        logic             pend;
        logic [VAL_W-1:0] tag;
        logic [VAL_W-1:0] maxv;
    } node_t;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
        node_t              data;
    } wr_req_t;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
    } rd_req_t;

endpackage

@@ hdl/range_chmin_max_segment_tree.sv @@
// Range cap / range max segment tree over 1024 leaves held in one node memory.
// After reset a clearing pass writes all 2048 nodes before s_ready rises.
// An item walks the tree one node at a time through the one memory read port: a node
// visited is read (S_RD), evaluated (S_EVAL) and stepped up from (S_UP), a pending cap
// is pushed to the children in S_PDL, S_PDR and S_PDK, and each parent on a load or cap
// is recomputed in S_PUL and S_PUR; a wide update or query touches up to about 40 nodes.
// A new item is taken only once the last one is done and s_ready is high again.
// Loads and caps give no result; a query gives one result word.
module range_chmin_max_segment_tree (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rcst_pkg::IDX_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rcst_pkg::CMD_W-1:0]  s_cmd,
    input  logic [rcst_pkg::IDX_W-1:0]  s_range_low,
    input  logic [rcst_pkg::IDX_W-1:0]  s_range_high,
    input  logic [rcst_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rcst_pkg::VAL_W-1:0]  m_max_value,
    output logic                        m_range_error
);
    import rcst_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EVAL, S_PDL, S_PDR, S_PDK, S_UP, S_PUL, S_PUR, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0]   span_reg, span_next, l_reg, l_next, r_reg, r_next;
    logic [IDX_W-1:0]   n_used_reg, n_used_next, clr_reg, clr_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [VAL_W-1:0]   val_reg, val_next, tag_reg, tag_next, kmax_reg, kmax_next;
    logic [VAL_W-1:0]   left_reg, left_next, best_reg, best_next, m_max_reg, m_max_next;
    logic               err_reg, err_next, m_valid_reg, m_valid_next, m_err_reg, m_err_next;

    rd_req_t            rd_req;
    wr_req_t            wr_req;
    node_t              rd;

    logic [IDX_W-1:0]   half, n_eff;
    logic               covered, go_left, bad_rng, bad_ld;

    rcst_node_mem u_mem (
        .aclk   (aclk),
        .rd_req (rd_req),
        .wr_req (wr_req),
        .rd_data(rd)
    );

    assign half    = span_reg >> 1;
    assign covered = (lo_reg >= l_reg) && (hi_reg <= r_reg);
    assign go_left = l_reg < (lo_reg + half);
    assign n_eff   = (n_used_reg > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : n_used_reg;
    assign bad_rng = (s_range_low == '0) || (s_range_low > s_range_high) ||
                     (s_range_high > n_eff);
    assign bad_ld  = (s_range_low == '0) || (s_range_low > n_eff);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        span_next    = span_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        tag_next     = tag_reg;
        kmax_next    = kmax_reg;
        left_next    = left_reg;
        best_next    = best_reg;
        err_next     = err_reg;
        m_max_next   = m_max_reg;
        m_err_next   = m_err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        n_used_next  = cfg_wr_en ? cfg_wr_data : n_used_reg;
        rd_req       = '0;
        wr_req       = '0;

        unique case (state_reg)
            S_CLEAR: begin
                wr_req.en   = 1'b1;
                wr_req.addr = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_cmd;
                    val_next  = s_value;
                    l_next    = s_range_low;
                    r_next    = s_range_high;
                    k_next    = IDX_W'(1);
                    lo_next   = IDX_W'(1);
                    hi_next   = IDX_W'(LEAVES);
                    span_next = IDX_W'(LEAVES);
                    best_next = '0;
                    err_next  = 1'b0;
                    case (s_cmd)
                        CMD_LOAD: begin
                            r_next = s_range_low;
                            if (!bad_ld) begin
                                state_next = S_RD;
                            end
                        end
                        CMD_CAP: begin
                            if (!bad_rng) begin
                                state_next = S_RD;
                            end
                        end
                        CMD_QUERY: begin
                            if (bad_rng) begin
                                err_next   = 1'b1;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                rd_req.en   = 1'b1;
                rd_req.addr = k_reg;
                state_next  = S_EVAL;
            end
            S_EVAL: begin
                tag_next  = rd.tag;
                kmax_next = rd.maxv;
                if (cmd_reg == CMD_QUERY && covered) begin
                    if (rd.maxv > best_reg) begin
                        best_next = rd.maxv;
                    end
                    state_next = S_UP;
                end else if (cmd_reg == CMD_CAP && rd.maxv <= val_reg) begin
                    state_next = S_UP;
                end else if (covered) begin
                    wr_req.en        = 1'b1;
                    wr_req.addr      = k_reg;
                    wr_req.data.pend = (cmd_reg == CMD_CAP);
                    wr_req.data.tag  = (cmd_reg == CMD_CAP) ? val_reg : '0;
                    wr_req.data.maxv = val_reg;
                    state_next       = S_UP;
                end else if (rd.pend) begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = {k_reg[IDX_W-2:0], 1'b0};
                    state_next  = S_PDL;
                end else begin
                    state_next = S_RD;
                    span_next  = half;
                    if (go_left) begin
                        k_next  = {k_reg[IDX_W-2:0], 1'b0};
                        hi_next = lo_reg + half - 1'b1;
                    end else begin
                        k_next  = {k_reg[IDX_W-2:0], 1'b1};
                        lo_next = lo_reg + half;
                    end
                end
            end
            S_PDL: begin
                wr_req.en   = rd.maxv > tag_reg;
                wr_req.addr = {k_reg[IDX_W-2:0], 1'b0};
                wr_req.data = '{pend: 1'b1, tag: tag_reg, maxv: tag_reg};
                rd_req.en   = 1'b1;
                rd_req.addr = {k_reg[IDX_W-2:0], 1'b1};
                state_next  = S_PDR;
            end
            S_PDR: begin
                wr_req.en   = rd.maxv > tag_reg;
                wr_req.addr = {k_reg[IDX_W-2:0], 1'b1};
                wr_req.data = '{pend: 1'b1, tag: tag_reg, maxv: tag_reg};
                state_next  = S_PDK;
            end
            S_PDK: begin
                wr_req.en   = 1'b1;
                wr_req.addr = k_reg;
                wr_req.data = '{pend: 1'b0, tag: '0, maxv: kmax_reg};
                state_next  = S_RD;
                span_next   = half;
                if (go_left) begin
                    k_next  = {k_reg[IDX_W-2:0], 1'b0};
                    hi_next = lo_reg + half - 1'b1;
                end else begin
                    k_next  = {k_reg[IDX_W-2:0], 1'b1};
                    lo_next = lo_reg + half;
                end
            end
            S_UP: begin
                if (k_reg == IDX_W'(1)) begin
                    state_next = (cmd_reg == CMD_QUERY) ? S_OUT : S_IDLE;
                end else if (!k_reg[0] && (hi_reg + 1'b1) <= r_reg) begin
                    k_next     = k_reg + 1'b1;
                    lo_next    = hi_reg + 1'b1;
                    hi_next    = hi_reg + span_reg;
                    state_next = S_RD;
                end else begin
                    k_next    = k_reg >> 1;
                    span_next = span_reg << 1;
                    if (k_reg[0]) begin
                        lo_next = lo_reg - span_reg;
                    end else begin
                        hi_next = hi_reg + span_reg;
                    end
                    if (cmd_reg != CMD_QUERY) begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = {k_reg[IDX_W-1:1], 1'b0};
                        state_next  = S_PUL;
                    end
                end
            end
            S_PUL: begin
                left_next   = rd.maxv;
                rd_req.en   = 1'b1;
                rd_req.addr = {k_reg[IDX_W-2:0], 1'b1};
                state_next  = S_PUR;
            end
            S_PUR: begin
                wr_req.en   = 1'b1;
                wr_req.addr = k_reg;
                wr_req.data = '{pend: 1'b0, tag: '0,
                                maxv: (left_reg > rd.maxv) ? left_reg : rd.maxv};
                state_next  = S_UP;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_max_next   = best_reg;
                    m_err_next   = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            n_used_reg  <= IDX_W'(LEAVES);
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            n_used_reg  <= n_used_next;
        end
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        span_reg  <= span_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        tag_reg   <= tag_next;
        kmax_reg  <= kmax_next;
        left_reg  <= left_next;
        best_reg  <= best_next;
        err_reg   <= err_next;
        m_max_reg <= m_max_next;
        m_err_reg <= m_err_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_max_value   = m_max_reg;
    assign m_range_error = m_err_reg;

endmodule

@@ hdl/rcst_node_mem.sv @@
// Node storage: one write port, one read port with registered read data.
module rcst_node_mem (
    input  logic            aclk,
    input  rcst_pkg::rd_req_t rd_req,
    input  rcst_pkg::wr_req_t wr_req,
    output rcst_pkg::node_t   rd_data
);
    import rcst_pkg::*;

    node_t mem [2**NODE_AW];
    node_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/rcst_checker.sv @@
// Port-level checks for the segment tree, bound to the top level.
`include "assert_macros.svh"

module rcst_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [rcst_pkg::CMD_W-1:0]  s_cmd,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rcst_pkg::VAL_W-1:0]  m_max_value,
    input logic                        m_range_error
);
    import rcst_pkg::*;

    `ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_valid && m_range_error, m_max_value == '0)
    `ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && s_cmd == CMD_QUERY, !s_ready)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_max_value))

endmodule

bind range_chmin_max_segment_tree rcst_checker u_rcst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_max_value  (m_max_value),
    .m_range_error(m_range_error)
);
